// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every rising clk edge outside reset.
`define SID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen on a rising clk edge outside reset.
`define SID_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SID_ASSERT(lbl, prop, msg)
`define SID_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hw/rtl/sid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_pkg
// Types, character codes and the powers-of-ten table for the signed
// integer to decimal text converter.
// ----------------------------------------------------------------------------
package sid_pkg;

  localparam int POW_DEPTH = 19;
  localparam int POW_IDX_W = 5;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [63:0] POW10 [POW_DEPTH] = '{
    64'd1,
    64'd10,
    64'd100,
    64'd1000,
    64'd10000,
    64'd100000,
    64'd1000000,
    64'd10000000,
    64'd100000000,
    64'd1000000000,
    64'd10000000000,
    64'd100000000000,
    64'd1000000000000,
    64'd10000000000000,
    64'd100000000000000,
    64'd1000000000000000,
    64'd10000000000000000,
    64'd100000000000000000,
    64'd1000000000000000000
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_SKIP,
    ST_DIGIT
  } state_t;

  // Number of decimal digits in the largest magnitude, 2^(w-1).
  function automatic int sid_num_digits(input int w);
    logic [63:0] lim;
    int          n;
    lim = 64'd1 << (w - 1);
    n   = 1;
    for (int i = 1; i < POW_DEPTH; i++) begin
      if (POW10[i] <= lim) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/sid_sub.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_sub
// Shared compare-subtract unit: a - b and whether b fits into a.
// ----------------------------------------------------------------------------
module sid_sub #(
  parameter int WIDTH = 35
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output logic             fits
);

  logic [WIDTH:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[WIDTH-1:0];
  // no borrow out means a >= b
  assign fits = ~full[WIDTH];

endmodule

// ----- hw/rtl/signed_int_to_decimal_ascii_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts one signed integer into its decimal text, one character per
// strobe, sign first, digits most significant first, no leading zeros.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  input     in_value                       start & !busy
//  result    out_character, out_last        out_valid, one cycle, no stall
//
// At most one compare-subtract is done per cycle. The largest magnitude has
// 10 digits at 32 bits; busy stays high from the accepted item until the
// last character is put out.
// Each digit is found by four restoring steps against 8, 4, 2, 1 times its
// power of ten; leading zero places are dropped one per cycle, and the
// SKIP state then finds the first printed place.
// busy falls on the edge that puts the last character out; the next item is
// taken at the edge after. Synchronous reset clears only state and out_valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_top
  import sid_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  output logic [7:0]                    out_character,
  output logic                          out_last
);

  localparam int NDIG  = sid_num_digits(VALUE_WIDTH);
  localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int AW    = VALUE_WIDTH + 3;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [1:0]             sh_r, sh_nxt;
  logic [3:0]             dig_r, dig_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [POW_IDX_W-1:0]   pow_idx;
  logic [AW-1:0]          sub_a, sub_b, sub_diff;
  logic                   sub_fits;
  logic [2:0]             shift_amt;
  logic [3:0]             dig_bit;

  assign pow_idx   = POW_IDX_W'(idx_r);
  assign shift_amt = (state_r == ST_DIGIT) ? {1'b0, sh_r} : 3'd0;
  assign sub_a     = {3'b000, mag_r};
  assign sub_b     = {3'b000, POW10[pow_idx][VALUE_WIDTH-1:0]} << shift_amt;
  assign dig_bit   = 4'b0001 << sh_r;

  sid_sub #(
    .WIDTH (AW)
  ) u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .fits (sub_fits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    idx_r      <= idx_nxt;
    sh_r       <= sh_nxt;
    dig_r      <= dig_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    idx_nxt       = idx_r;
    sh_nxt        = sh_r;
    dig_nxt       = dig_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // unsigned negation keeps the most negative value exact
          mag_nxt   = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
          idx_nxt   = IDX_W'(NDIG - 1);
          state_nxt = in_value[VALUE_WIDTH-1] ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = CHAR_MINUS;
        out_last_nxt  = 1'b0;
        state_nxt     = ST_SKIP;
      end
      ST_SKIP: begin
        // drop leading zero places; the units place always prints
        if (idx_r != '0 && !sub_fits) begin
          idx_nxt = idx_r - 1'b1;
        end else begin
          sh_nxt    = 2'd3;
          dig_nxt   = 4'd0;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sub_fits) begin
          mag_nxt = sub_diff[VALUE_WIDTH-1:0];
          dig_nxt = dig_r | dig_bit;
        end
        if (sh_r == 2'd0) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {4'd0, dig_nxt};
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
            sh_nxt  = 2'd3;
            dig_nxt = 4'd0;
          end
        end else begin
          sh_nxt = sh_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  `SID_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
  `SID_ASSERT(a_out_in_work, out_valid |-> $past(busy), "character without an item in work")
  `SID_ASSERT(a_last_idle, (out_valid && out_last) |-> !busy, "busy after last character")
  `SID_NEVER(a_bad_char, out_valid && out_character != CHAR_MINUS &&
    (out_character < CHAR_ZERO || out_character > CHAR_NINE), "character out of range")

endmodule
